@@ hdl/iir4_pkg.sv @@
// ----------------------------------------------------------------------------
// iir4_pkg: shared types and constants for the order-4 IIR filter
// Holds the fixed coefficient table and the sequencer control word.
// ----------------------------------------------------------------------------
package iir4_pkg;

  localparam int unsigned NumTaps   = 9;
  localparam int unsigned TapBits   = 4;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned HistBits  = 32;
  localparam int unsigned HistFrac  = 16;
  localparam int unsigned CoefBits  = 32;
  localparam int unsigned AccBits   = 66;
  localparam int unsigned DigitBits = 4;
  localparam int unsigned NumDigits = 8;   // multiplier operand bits / DigitBits
  localparam int unsigned DigCntBits = 3;

  // Coefficient magnitudes times 10^10 and signs, taps b0..b4, a1..a4.
  localparam longint unsigned CoefMag [NumTaps] = '{
    64'd3851645, 64'd15406580, 64'd23119870, 64'd15406580, 64'd3851645,
    64'd23651740000, 64'd23139880000, 64'd10541600000, 64'd1785570000};
  localparam bit CoefNeg [NumTaps] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  // Rounded fixed-point coefficient; evaluated at elaboration only.
  function automatic longint make_coef(input int unsigned k, input int unsigned frac);
    longint unsigned m;
    longint q;
    m = (CoefMag[k] << frac) + 64'd5000000000;
    q = longint'(m / 64'd10000000000);
    return CoefNeg[k] ? -q : q;
  endfunction

  // Control word from the sequencer to the serial MAC.
  typedef struct packed {
    logic                  load;    // start a new product
    logic                  digit;   // shift one digit of the multiplier
    logic                  last;    // last digit of this product
    logic                  clear;   // clear accumulator
  } mac_ctrl_t;

endpackage

@@ hdl/iir4_mac.sv @@
// ----------------------------------------------------------------------------
// iir4_mac: digit-serial multiply-accumulate unit
// Multiplies a 32-bit signed coefficient by a 32-bit signed operand, four
// bits per cycle while digit is set, and adds the product into a wide sum.
// ----------------------------------------------------------------------------
module iir4_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iir4_pkg::mac_ctrl_t           ctrl_i,
  input  logic signed [iir4_pkg::CoefBits-1:0] coef_i,
  input  logic signed [iir4_pkg::HistBits-1:0] opnd_i,
  output logic signed [iir4_pkg::AccBits-1:0]  acc_o
);
  localparam int unsigned W = iir4_pkg::HistBits;
  localparam int unsigned D = iir4_pkg::DigitBits;
  localparam int unsigned A = iir4_pkg::AccBits;

  logic [W-1:0]          opnd_q, opnd_d;
  logic signed [A-1:0]   part_q, part_d;   // partial product, low digits first
  logic signed [A-1:0]   acc_q, acc_d;
  logic signed [iir4_pkg::CoefBits-1:0] coef_q;
  logic signed [iir4_pkg::CoefBits+D:0] pp;
  logic signed [D:0]     dig;

  // The top digit carries the operand sign; lower digits are unsigned.
  always_comb begin
    dig = ctrl_i.last ? {opnd_q[D-1], opnd_q[D-1:0]} : {1'b0, opnd_q[D-1:0]};
    pp  = (iir4_pkg::CoefBits+D+1)'(coef_q) * dig;
    opnd_d = opnd_q >> D;
    // Shift the product right one digit each step; the sum is rebuilt by
    // adding each digit product at the top and moving down.
    part_d = (part_q >>> D) + ($signed({pp, (A-iir4_pkg::CoefBits-D-1)'(0)}));
    acc_d  = acc_q;
    if (ctrl_i.clear) acc_d = '0;
    else if (ctrl_i.last) acc_d = acc_q + (part_d >>> (A-iir4_pkg::CoefBits-D-1-(W-D)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      opnd_q <= opnd_i;
      coef_q <= coef_i;
      part_q <= '0;
    end else if (ctrl_i.digit) begin
      opnd_q <= opnd_d;
      part_q <= part_d;
    end
  end

  assign acc_o = acc_q;
endmodule

@@ hdl/iir_order4_direct_form_one.sv @@
// ----------------------------------------------------------------------------
// iir_order4_direct_form_one: fourth-order direct-form-I low-pass filter
// One digit-serial MAC runs nine products of four-bit digits per sample.
// ----------------------------------------------------------------------------
// Each accepted input word runs nine products, each of one load step and
// eight digit steps, then one rounding step before a valid output word.
// No new input word is taken until the current one has left the rounding step.
// The next input word is taken while a finished result waits at the output;
// a new result is held in the rounding step until the output register is free.
// Reset clears all input and output history and empties the output register.
module iir_order4_direct_form_one #(
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample_in[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample_out[15:0]
  output logic        m_axis_tuser    // clipped
);
  localparam int unsigned H = iir4_pkg::HistBits;
  localparam int unsigned A = iir4_pkg::AccBits;
  localparam int unsigned SB = iir4_pkg::SampleBits;
  localparam int unsigned HistFracW = iir4_pkg::HistFrac;
  localparam int unsigned YW = A - COEF_FRAC_BITS;
  localparam int unsigned RW = H - HistFracW + 1;
  localparam logic signed [YW-1:0] YMax = YW'({1'b0, {(H-1){1'b1}}});
  localparam logic signed [YW-1:0] YMin = -YMax - YW'(1);
  localparam logic signed [RW-1:0] RMax = RW'({1'b0, {(SB-1){1'b1}}});
  localparam logic signed [RW-1:0] RMin = -RMax - RW'(1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StLoad  = 4'b0010,
    StDigit = 4'b0100,
    StRound = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [iir4_pkg::TapBits-1:0]    tap_q, tap_d;
  logic [iir4_pkg::DigCntBits-1:0] dig_q, dig_d;
  logic signed [SB-1:0]          xh_q [5];
  logic signed [H-1:0]           yh_q [4];
  logic signed [H-1:0]           opnd;
  logic signed [iir4_pkg::CoefBits-1:0] coef;
  logic signed [A-1:0]           acc;
  iir4_pkg::mac_ctrl_t           ctrl;
  logic                          ovalid_q;
  logic [15:0]                   odata_q;
  logic                          oclip_q;
  logic                          round_go;
  logic signed [A-1:0]           sum_r;
  logic signed [YW-1:0]          y_wide;
  logic signed [H-1:0]           y_sat;
  logic                          clip_y;
  logic signed [H:0]             y_rnd;
  logic signed [RW-1:0]          r_wide;
  logic signed [SB-1:0]          r_sat;
  logic                          clip_r;

  function automatic logic signed [iir4_pkg::CoefBits-1:0] coef_at(
      input logic [iir4_pkg::TapBits-1:0] k);
    logic signed [iir4_pkg::CoefBits-1:0] c;
    c = '0;
    for (int unsigned i = 0; i < iir4_pkg::NumTaps; i++) begin
      if (k == iir4_pkg::TapBits'(i))
        c = iir4_pkg::CoefBits'(iir4_pkg::make_coef(i, COEF_FRAC_BITS));
    end
    // Feedback taps enter with negated sign.
    return (k >= iir4_pkg::TapBits'(5)) ? -c : c;
  endfunction

  // Inputs are scaled by 2^16 so every product has COEF_FRAC_BITS + 16
  // fraction bits.
  always_comb begin
    coef = coef_at(tap_q);
    if (tap_q < iir4_pkg::TapBits'(5))
      opnd = {xh_q[tap_q[2:0]], HistFracW'(0)};
    else
      opnd = yh_q[2'(tap_q - iir4_pkg::TapBits'(5))];
  end

  assign s_axis_tready = (state_q == StIdle);
  assign round_go      = (state_q == StRound) && (!ovalid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    dig_d   = dig_q;
    ctrl    = '0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ctrl.clear = 1'b1;
          tap_d   = '0;
          state_d = StLoad;
        end
      end
      StLoad: begin
        ctrl.load = 1'b1;
        dig_d   = '0;
        state_d = StDigit;
      end
      StDigit: begin
        ctrl.digit = 1'b1;
        ctrl.last  = (dig_q == iir4_pkg::DigCntBits'(iir4_pkg::NumDigits-1));
        dig_d = dig_q + 1'b1;
        if (ctrl.last) begin
          if (tap_q == iir4_pkg::TapBits'(iir4_pkg::NumTaps-1)) begin
            state_d = StRound;
          end else begin
            tap_d   = tap_q + 1'b1;
            state_d = StLoad;
          end
        end
      end
      StRound: begin
        if (round_go) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Round half up to 16 fraction bits, saturate to 32 bits, then to a sample.
  always_comb begin
    sum_r  = acc + (A'(1) <<< (COEF_FRAC_BITS-1));
    y_wide = sum_r[A-1:COEF_FRAC_BITS];
    clip_y = (y_wide > YMax) || (y_wide < YMin);
    if (clip_y) y_sat = y_wide[YW-1] ? {1'b1, {(H-1){1'b0}}}
                                     : {1'b0, {(H-1){1'b1}}};
    else        y_sat = y_wide[H-1:0];
    y_rnd  = (H+1)'(y_sat) + (H+1)'(1 << (HistFracW-1));
    r_wide = y_rnd[H:HistFracW];
    clip_r = (r_wide > RMax) || (r_wide < RMin);
    if (clip_r) r_sat = r_wide[RW-1] ? {1'b1, {(SB-1){1'b0}}}
                                     : {1'b0, {(SB-1){1'b1}}};
    else        r_sat = r_wide[SB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      tap_q    <= '0;
      dig_q    <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 5; i++) xh_q[i] <= '0;
      for (int i = 0; i < 4; i++) yh_q[i] <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      dig_q   <= dig_d;
      if (round_go) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (s_axis_tvalid && s_axis_tready) xh_q[0] <= s_axis_tdata[SB-1:0];
      if (round_go) begin
        for (int i = 1; i < 5; i++) xh_q[i] <= xh_q[i-1];
        yh_q[0] <= y_sat;
        for (int i = 1; i < 4; i++) yh_q[i] <= yh_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (round_go) begin
      odata_q <= 16'(r_sat);
      oclip_q <= clip_y || clip_r;
    end
  end

  iir4_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .coef_i (coef),
    .opnd_i (opnd),
    .acc_o  (acc)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = oclip_q;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_round_to_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |=> m_axis_tvalid) else $error("result not shown");
endmodule
